// ----- sv/cpa_pkg.sv -----
// Shared types, constants and helpers for the coin pulse acceptor channel.
// Used by cpa_step, cpa_rfifo and coin_pulse_acceptor_channel_core.
`default_nettype none

package cpa_pkg;

  localparam int unsigned DEBOUNCE_BITS = 4;
  localparam logic [7:0]  HIST_MASK     = 8'((1 << DEBOUNCE_BITS) - 1);
  localparam logic [15:0] TICK_MS       = 16'd2;
  localparam logic [15:0] REPORT_CAP    = 16'h00FF;
  localparam logic [15:0] SAT16         = 16'hFFFF;
  localparam int unsigned RFIFO_DEPTH   = 4;
  localparam int unsigned RFIFO_AW      = $clog2(RFIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_ACK   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_ENABLE  = 3'd0,
    REG_ACTIVE_LEVEL    = 3'd1,
    REG_MIN_PULSE_MS    = 3'd2,
    REG_MAX_PULSE_MS    = 3'd3,
    REG_JAM_MS          = 3'd4,
    REG_REPORT_DELAY_MS = 3'd5
  } reg_index_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_CLEAR = 1'b1
  } command_t;

  typedef struct packed {
    logic command;
    logic sample_level;
    logic value_report_taken;
    logic error_report_taken;
  } tick_t;

  typedef struct packed {
    kind_t      report_kind;
    logic [7:0] amount;
    logic       error_flag;
    logic       last;
  } report_t;

  typedef struct packed {
    logic        channel_enable;
    logic        active_level;
    logic [7:0]  min_pulse_ms;
    logic [7:0]  max_pulse_ms;
    logic [7:0]  jam_ms;
    logic [15:0] report_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  sample_history;
    logic        debounced_level;
    logic        previous_level;
    logic [15:0] active_time;
    logic [15:0] coin_count;
    logic [15:0] pending_report;
    logic [15:0] delay_timer;
    logic        jam_error;
    logic        error_pending;
  } chan_state_t;

  typedef struct packed {
    logic [1:0] num;
    report_t    word0;
    report_t    word1;
  } push_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? SAT16 : s[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/cpa_step.sv -----
// Single-pass tick logic: next channel state and up to two report words.
// Depends on cpa_pkg.
`default_nettype none

module cpa_step
  import cpa_pkg::*;
(
  input  tick_t       tick,
  input  cfg_t        cfg,
  input  chan_state_t state,
  output chan_state_t state_next,
  output push_t       push
);

  report_t     val_word;
  report_t     err_word;
  logic        val_hit;
  logic        err_hit;
  logic [7:0]  hist;
  logic [7:0]  hist_low;
  logic        deb;
  logic [15:0] at;
  logic [15:0] cc;
  logic [15:0] dt;

  always_comb begin
    state_next = state;
    push       = '0;
    val_word   = '0;
    err_word   = '0;
    val_hit    = 1'b0;
    err_hit    = 1'b0;
    hist       = state.sample_history;
    hist_low   = '0;
    deb        = state.debounced_level;
    at         = state.active_time;
    cc         = state.coin_count;
    dt         = state.delay_timer;

    if (tick.command == CMD_CLEAR) begin
      state_next.jam_error     = 1'b0;
      state_next.error_pending = 1'b0;
      push.num               = 2'd1;
      push.word0.report_kind = KIND_ACK;
      push.word0.last        = 1'b1;
    end else if (cfg.channel_enable) begin
      if (state.pending_report != '0) begin
        val_hit                 = 1'b1;
        val_word.report_kind    = KIND_VALUE;
        val_word.error_flag     = state.jam_error;
        if (state.pending_report >= REPORT_CAP) begin
          val_word.amount = REPORT_CAP[7:0];
          if (tick.value_report_taken) begin
            state_next.pending_report = state.pending_report - REPORT_CAP;
          end
        end else begin
          val_word.amount = state.pending_report[7:0];
          if (tick.value_report_taken) begin
            state_next.pending_report = '0;
          end
        end
      end

      if (state.delay_timer >= cfg.report_delay_ms) begin
        if (state.coin_count != '0) begin
          state_next.pending_report = state.coin_count;
          cc = '0;
        end
      end else begin
        dt = sat_add16(state.delay_timer, TICK_MS);
      end

      if (state.error_pending) begin
        err_hit              = 1'b1;
        err_word.report_kind = KIND_ERROR;
        err_word.error_flag  = 1'b1;
        if (tick.error_report_taken) begin
          state_next.jam_error     = 1'b1;
          state_next.error_pending = 1'b0;
        end
      end

      if ((state.active_time >= {8'd0, cfg.jam_ms}) && !state_next.jam_error) begin
        state_next.error_pending = 1'b1;
      end

      hist     = {state.sample_history[6:0], tick.sample_level};
      hist_low = hist & HIST_MASK;
      if (hist_low == '0) begin
        deb = 1'b0;
      end else if (hist_low == HIST_MASK) begin
        deb = 1'b1;
      end

      if (deb == cfg.active_level) begin
        at = sat_add16(at, TICK_MS);
      end

      if ((deb != state.previous_level) && (deb != cfg.active_level)) begin
        if ((at >= {8'd0, cfg.min_pulse_ms}) && (at <= {8'd0, cfg.max_pulse_ms})) begin
          dt = '0;
          cc = sat_add16(cc, 16'd1);
        end
        at = '0;
      end

      state_next.sample_history  = hist;
      state_next.debounced_level = deb;
      state_next.previous_level  = deb;
      state_next.active_time     = at;
      state_next.coin_count      = cc;
      state_next.delay_timer     = dt;

      if (val_hit && err_hit) begin
        push.num        = 2'd2;
        push.word0      = val_word;
        push.word1      = err_word;
        push.word1.last = 1'b1;
      end else if (val_hit) begin
        push.num        = 2'd1;
        push.word0      = val_word;
        push.word0.last = 1'b1;
      end else if (err_hit) begin
        push.num        = 2'd1;
        push.word0      = err_word;
        push.word0.last = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cpa_rfifo.sv -----
// Report word queue: takes up to two words per cycle, hands out one.
// Depends on cpa_pkg.
`default_nettype none

module cpa_rfifo
  import cpa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_en,
  input  push_t   push,
  output logic    room,
  output logic    report_valid,
  input  logic    report_ready,
  output report_t report
);

  report_t             mem [RFIFO_DEPTH];
  logic [RFIFO_AW-1:0] wr_ptr;
  logic [RFIFO_AW-1:0] rd_ptr;
  logic [RFIFO_AW:0]   count;
  logic [RFIFO_AW:0]   count_next;
  logic [1:0]          push_num;
  logic                pop;

  assign push_num     = push_en ? push.num : 2'd0;
  assign pop          = report_valid && report_ready;
  assign report_valid = (count != '0);
  assign report       = mem[rd_ptr];
  assign room         = (count <= (RFIFO_AW + 1)'(RFIFO_DEPTH - 2));
  assign count_next   = count + (RFIFO_AW + 1)'(push_num) - (RFIFO_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem[wr_ptr] <= push.word0;
    end
    if (push_num == 2'd2) begin
      mem[wr_ptr + RFIFO_AW'(1)] <= push.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RFIFO_AW'(push_num);
      rd_ptr <= rd_ptr + RFIFO_AW'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/coin_pulse_acceptor_channel_core.sv -----
// Coin pulse acceptor channel: one tick word in, up to two report words out.
// A report word is registered into the report queue when its tick is accepted.
// Throughput: one tick per cycle while the report queue holds two or fewer
// words; the sink's pop rate on the 4-deep report queue sets the long-run pace.
// Reset (synchronous, rst high) restores register defaults and clears state.
`default_nettype none

module coin_pulse_acceptor_channel_core
  import cpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_ready,
  input  tick_t       tick,
  output logic        report_valid,
  input  logic        report_ready,
  output report_t     report,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);

  cfg_t        cfg;
  chan_state_t state;
  chan_state_t state_next;
  push_t       push;
  logic        accept;
  logic        room;

  assign tick_ready = room;
  assign accept     = tick_valid && tick_ready;

  cpa_step u_step (
    .tick       (tick),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .push       (push)
  );

  cpa_rfifo u_rfifo (
    .clk          (clk),
    .rst          (rst),
    .push_en      (accept),
    .push         (push),
    .room         (room),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_enable  <= 1'b0;
      cfg.active_level    <= 1'b1;
      cfg.min_pulse_ms    <= 8'd0;
      cfg.max_pulse_ms    <= 8'd255;
      cfg.jam_ms          <= 8'd255;
      cfg.report_delay_ms <= 16'd0;
      state               <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNEL_ENABLE:  cfg.channel_enable <= wr_data[0];
        REG_ACTIVE_LEVEL: begin
          cfg.active_level     <= wr_data[0];
          state.previous_level <= ~wr_data[0];
        end
        REG_MIN_PULSE_MS:    cfg.min_pulse_ms <= wr_data[7:0];
        REG_MAX_PULSE_MS:    cfg.max_pulse_ms <= wr_data[7:0];
        REG_JAM_MS:          cfg.jam_ms <= wr_data[7:0];
        REG_REPORT_DELAY_MS: begin
          cfg.report_delay_ms <= wr_data;
          state.delay_timer   <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
